### design/ansi_escape_parser_core_macros.svh
// Assertion macros shared by the escape parser modules.
`ifndef ANSI_ESCAPE_PARSER_CORE_MACROS_SVH
`define ANSI_ESCAPE_PARSER_CORE_MACROS_SVH

// checked on every clock edge outside reset
`define AEP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define AEP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/aep_pkg.sv
// Types, character codes and conversion helpers for the escape sequence parser.
`timescale 1ns / 1ps
`default_nettype none

package aep_pkg;

	// result kinds
	typedef enum logic [3:0] {
		OP_NOTHING  = 4'd0,
		OP_START    = 4'd1,
		OP_CLEAR    = 4'd2,
		OP_MOVETO   = 4'd3,
		OP_RESET    = 4'd4,
		OP_COLOR    = 4'd5,
		OP_UP       = 4'd6,
		OP_DOWN     = 4'd7,
		OP_RIGHT    = 4'd8,
		OP_LEFT     = 4'd9,
		OP_ROLLBACK = 4'd10
	} op_kind_t;

	// character codes
	localparam logic [7:0] CH_ESC      = 8'd27;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_J        = 8'h4A;
	localparam logic [7:0] CH_H        = 8'h48;
	localparam logic [7:0] CH_M_LOWER  = 8'h6D;
	localparam logic [7:0] CH_A        = 8'h41;
	localparam logic [7:0] CH_B        = 8'h42;
	localparam logic [7:0] CH_C        = 8'h43;
	localparam logic [7:0] CH_D        = 8'h44;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;

	// controller to datapath
	typedef struct packed {
		logic take;   // accept the input request and decode it
		logic emit;   // load the next replayed byte into the output register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rollback;     // current input starts a replay
		logic replay_last;  // replay pointer is on the newest stored byte
	} dp_status_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// strtol-like conversion of a one or two character field
	function automatic logic signed [7:0] to_number(input logic [7:0] c0,
			input logic [7:0] c1, input logic two);
		logic [7:0]        ch [2];
		logic [1:0]        n;
		logic [1:0]        i;
		logic              neg;
		logic              stop;
		logic [6:0]        v;
		logic signed [7:0] sv;
		ch[0] = c0;
		ch[1] = c1;
		n     = two ? 2'd2 : 2'd1;
		if (c0 == 8'd0) begin
			n = 2'd0;
		end else if (n == 2'd2 && c1 == 8'd0) begin
			n = 2'd1;
		end
		i    = 2'd0;
		neg  = 1'b0;
		v    = 7'd0;
		stop = 1'b0;
		// leading white space
		for (int k = 0; k < 2; k++) begin
			if (!stop && i < n && is_space(ch[i[0]])) begin
				i = i + 2'd1;
			end else begin
				stop = 1'b1;
			end
		end
		// optional sign
		if (i < n && (ch[i[0]] == CH_PLUS || ch[i[0]] == CH_MINUS)) begin
			neg = (ch[i[0]] == CH_MINUS);
			i   = i + 2'd1;
		end
		// digits
		stop = 1'b0;
		for (int k = 0; k < 2; k++) begin
			if (!stop && i < n && is_digit(ch[i[0]])) begin
				v = 7'(v * 7'd10 + {3'b000, ch[i[0]][3:0]});
				i = i + 2'd1;
			end else begin
				stop = 1'b1;
			end
		end
		sv = {1'b0, v};
		return neg ? -sv : sv;
	endfunction

endpackage

`default_nettype wire

### design/aep_dpath.sv
// Datapath: sequence store, parameter parsing, command decode and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_escape_parser_core_macros.svh"

module aep_dpath #(
	parameter int STORE_DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  [7:0]              char_in,
	input  aep_pkg::ctrl_cmd_t      cmd,
	output aep_pkg::dp_status_t     status,
	output aep_pkg::op_kind_t       op_kind,
	output logic signed [7:0]       first_param,
	output logic signed [7:0]       second_param,
	output logic [7:0]              rollback_byte,
	output logic                    last_of_run,
	output logic                    in_sequence
);
	import aep_pkg::*;

	localparam int LEN_W = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W = $clog2(STORE_DEPTH);

	logic             active_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       store_q [STORE_DEPTH];
	logic [IDX_W-1:0] rb_idx_q;

	logic [7:0]        view [7];
	logic [LEN_W-1:0]  len_next;
	logic [IDX_W-1:0]  wr_idx;
	logic              full;
	logic              bracket_end;
	logic              known;
	logic              rollback;
	logic              replay_last;
	logic signed [7:0] p1, p2;
	op_kind_t          res_op;
	logic signed [7:0] res_p1, res_p2;
	logic              res_inseq;

	// store as seen with the incoming byte already placed
	always_comb begin
		for (int k = 0; k < 7; k++) begin
			view[k] = (LEN_W'(k) == len_q) ? char_in : store_q[k];
		end
	end

	assign len_next    = len_q + LEN_W'(1);
	assign wr_idx      = len_q[IDX_W-1:0];
	assign full        = len_next == LEN_W'(STORE_DEPTH);
	assign bracket_end = (view[0] == CH_LBRACKET) && is_letter(char_in);
	assign replay_last = (LEN_W'(rb_idx_q) + LEN_W'(1)) == len_q;

	// parameter layouts, tried in order
	always_comb begin
		p1 = '0;
		p2 = '0;
		if (is_letter(view[1])) begin
			p1 = '0;
		end else if (view[2] == CH_SEMI && is_letter(view[4])) begin
			p1 = to_number(view[1], 8'd0, 1'b0);
			p2 = to_number(view[3], 8'd0, 1'b0);
		end else if (view[2] == CH_SEMI && is_letter(view[5])) begin
			p1 = to_number(view[1], 8'd0, 1'b0);
			p2 = to_number(view[3], view[4], 1'b1);
		end else if (view[3] == CH_SEMI && is_letter(view[5])) begin
			p1 = to_number(view[1], view[2], 1'b1);
			p2 = to_number(view[4], 8'd0, 1'b0);
		end else if (view[3] == CH_SEMI && is_letter(view[6])) begin
			p1 = to_number(view[1], view[2], 1'b1);
			p2 = to_number(view[4], view[5], 1'b1);
		end else if (is_letter(view[2])) begin
			p1 = to_number(view[1], 8'd0, 1'b0);
		end else if (is_letter(view[3])) begin
			p1 = to_number(view[1], view[2], 1'b1);
		end
	end

	// result of one input request
	always_comb begin
		known     = 1'b1;
		res_op    = OP_NOTHING;
		res_p1    = '0;
		res_p2    = '0;
		res_inseq = 1'b0;
		if (!active_q) begin
			res_op    = (char_in == CH_ESC) ? OP_START : OP_NOTHING;
			res_inseq = (char_in == CH_ESC);
		end else if (!bracket_end) begin
			res_inseq = 1'b1;
		end else begin
			case (char_in)
				CH_J: res_op = OP_CLEAR;
				CH_H: begin
					res_op = OP_MOVETO;
					res_p1 = p1;
					res_p2 = p2;
				end
				CH_M_LOWER: begin
					if (p1 == 8'sd0 && p2 == 8'sd0) begin
						res_op = OP_RESET;
					end else begin
						res_op = OP_COLOR;
						res_p1 = p1;
						res_p2 = p2;
					end
				end
				CH_A: begin
					res_op = OP_UP;
					res_p1 = p1;
				end
				CH_B: begin
					res_op = OP_DOWN;
					res_p1 = p1;
				end
				CH_C: begin
					res_op = OP_RIGHT;
					res_p1 = p1;
				end
				CH_D: begin
					res_op = OP_LEFT;
					res_p1 = p1;
				end
				default: known = 1'b0;
			endcase
		end
	end

	// a full store wins over decoding
	assign rollback = active_q && (full || (bracket_end && !known));

	assign status.rollback    = rollback;
	assign status.replay_last = replay_last;

	// sequence state and store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			len_q    <= '0;
			rb_idx_q <= '0;
			for (int k = 0; k < STORE_DEPTH; k++) begin
				store_q[k] <= 8'd0;
			end
		end else if (cmd.take) begin
			if (!active_q) begin
				active_q <= (char_in == CH_ESC);
			end else if (rollback || !bracket_end) begin
				store_q[wr_idx] <= char_in;
				len_q           <= len_next;
				rb_idx_q        <= '0;
			end else begin
				active_q <= 1'b0;
				len_q    <= '0;
				for (int k = 0; k < STORE_DEPTH; k++) begin
					store_q[k] <= 8'd0;
				end
			end
		end else if (cmd.emit) begin
			rb_idx_q <= rb_idx_q + IDX_W'(1);
			if (replay_last) begin
				active_q <= 1'b0;
				len_q    <= '0;
				for (int k = 0; k < STORE_DEPTH; k++) begin
					store_q[k] <= 8'd0;
				end
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (cmd.take && !rollback) begin
			op_kind       <= res_op;
			first_param   <= res_p1;
			second_param  <= res_p2;
			rollback_byte <= 8'd0;
			last_of_run   <= 1'b1;
			in_sequence   <= res_inseq;
		end else if (cmd.emit) begin
			op_kind       <= OP_ROLLBACK;
			first_param   <= '0;
			second_param  <= '0;
			rollback_byte <= store_q[rb_idx_q];
			last_of_run   <= replay_last;
			in_sequence   <= 1'b0;
		end
	end

	`AEP_ASSERT(a_len_bounded, len_q <= LEN_W'(STORE_DEPTH), "store length overrun")
	`AEP_ASSERT(a_idle_empty, !active_q |-> (len_q == '0), "idle parser holds stored bytes")

endmodule

`default_nettype wire

### design/aep_ctrl.sv
// Controller: input/output handshake and the replay sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_escape_parser_core_macros.svh"

module aep_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  aep_pkg::dp_status_t  status,
	output aep_pkg::ctrl_cmd_t   cmd
);
	import aep_pkg::*;

	typedef enum logic {
		ST_RUN,
		ST_REPLAY
	} state_t;

	state_t state_q;
	logic   m_valid_q;
	logic   slot_free;
	logic   load;

	// output register free, or emptied this cycle
	assign slot_free = !m_valid_q || out_ready;
	assign in_ready  = (state_q == ST_RUN) && slot_free;
	assign cmd.take  = in_ready && in_valid;
	assign cmd.emit  = (state_q == ST_REPLAY) && slot_free;
	assign load      = (cmd.take && !status.rollback) || cmd.emit;
	assign out_valid = m_valid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (cmd.take && status.rollback) begin
						state_q <= ST_REPLAY;
					end
				end
				ST_REPLAY: begin
					if (cmd.emit && status.replay_last) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	`AEP_ASSERT(a_take_emit_excl, !(cmd.take && cmd.emit), "request taken during replay")
	`AEP_ASSERT(a_enter_replay, (cmd.take && status.rollback) |=> (state_q == ST_REPLAY && !m_valid_q), "rollback did not start replay")
	`AEP_ASSERT(a_leave_replay, (cmd.emit && status.replay_last) |=> (state_q == ST_RUN && m_valid_q), "replay did not end on last byte")

endmodule

`default_nettype wire

### design/ansi_escape_parser_core.sv
// Top level of the ANSI escape sequence parser.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Input channel s_axis: one character per request in s_axis_tdata[7:0].
// Output channel m_axis: one result per request; a rollback gives one result
// per stored byte. m_axis_tlast marks the final result of an input request,
// m_axis_tuser is high while a sequence is still being collected.
// A result of a request that starts no rollback is registered: it appears in
// the output register in the cycle after its request is taken.
// Throughput: one character per cycle while no rollback occurs and m_axis is
// not stalled. A rollback captures the current byte, then replays one stored
// byte per cycle unless stalled; s_axis_tready is low throughout the replay.
// Stalls: the output register is refilled in the cycle it is read, so outside a
// replay a request is taken whenever m_axis_tready is high or the register is
// empty; while m_axis_tready stays low the held result and all state are kept.
// Reset: arst_n clears the store, the length count, the replay pointer and
// the output valid; the parser then waits outside a sequence.

module ansi_escape_parser_core #(
	parameter int STORE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] char_in
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [3:0] op_kind, [11:4] first_param, [19:12] second_param,
	// [27:20] rollback_byte, [31:28] zero
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,   // last_of_run
	output logic        m_axis_tuser    // [0] in_sequence
);
	import aep_pkg::*;

	ctrl_cmd_t         cmd;
	dp_status_t        status;
	op_kind_t          op_kind;
	logic signed [7:0] first_param;
	logic signed [7:0] second_param;
	logic [7:0]        rollback_byte;

	aep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	aep_dpath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_in       (s_axis_tdata),
		.cmd           (cmd),
		.status        (status),
		.op_kind       (op_kind),
		.first_param   (first_param),
		.second_param  (second_param),
		.rollback_byte (rollback_byte),
		.last_of_run   (m_axis_tlast),
		.in_sequence   (m_axis_tuser)
	);

	assign m_axis_tdata = {4'b0000, rollback_byte, second_param, first_param, op_kind};

endmodule

`default_nettype wire
